### src/button_edge_autorepeat_assert.svh
// Assertion macros shared by the button edge/auto-repeat RTL.
`ifndef BUTTON_EDGE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_EDGE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bea_pkg.sv
// Package: widths, register indexes and result type for the button edge/auto-repeat block.
package bea_pkg;

  localparam int HELD_W      = 14;
  localparam int REPEAT_W    = 10;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 56;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int RES_W       = 3 * HELD_W + REPEAT_W;

  localparam logic [CFG_DATA_W-1:0] START_DELAY_RST  = 8'd15;
  localparam logic [CFG_DATA_W-1:0] PERIOD_DELAY_RST = 8'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_DELAY  = 8'd0,
    CFG_PERIOD_DELAY = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic [HELD_W-1:0]   held_mask;
    logic [REPEAT_W-1:0] repeat_mask;
    logic [HELD_W-1:0]   released_mask;
    logic [HELD_W-1:0]   pressed_mask;
  } res_t;

endpackage

### src/bea_core.sv
// Edge detection and per-button repeat countdowns; state advances on each processed sample.
module bea_core
  import bea_pkg::*;
#(
  parameter int NUM_BUTTONS   = 10,
  parameter int COUNTER_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [HELD_W-1:0]        held,
  input  logic [COUNTER_WIDTH-1:0] start_delay,
  input  logic [COUNTER_WIDTH-1:0] period_delay,
  output res_t                     res
);

  logic [HELD_W-1:0] previous_held;
  logic [HELD_W-1:0] pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_held <= '0;
    end else if (en) begin
      previous_held <= held;
    end
  end

  for (genvar i = 0; i < HELD_W; i++) begin : g_btn
    if (i < NUM_BUTTONS) begin : g_cnt
      logic [COUNTER_WIDTH-1:0] count;
      logic [COUNTER_WIDTH-1:0] count_next;
      logic [COUNTER_WIDTH-1:0] count_dec;
      logic                     pulse_bit;

      assign count_dec = count - COUNTER_WIDTH'(1);
      assign pulse[i]  = pulse_bit;

      always_comb begin
        pulse_bit  = 1'b0;
        count_next = '0;
        if (held[i]) begin
          if (!previous_held[i]) begin
            pulse_bit  = 1'b1;
            count_next = start_delay;
          end else if (count_dec == '0) begin
            pulse_bit  = 1'b1;
            count_next = period_delay;
          end else begin
            count_next = count_dec;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          count <= '0;
        end else if (en) begin
          count <= count_next;
        end
      end
    end else begin : g_none
      assign pulse[i] = 1'b0;
    end
  end

  assign res.pressed_mask  = held & ~previous_held;
  assign res.released_mask = previous_held & ~held;
  assign res.repeat_mask   = pulse[REPEAT_W-1:0];
  assign res.held_mask     = held;

endmodule

### src/button_edge_autorepeat.sv
// Top level: button edge detection with typematic auto-repeat on a streaming interface.
//
// One 14-bit held-button sample per input transaction gives exactly one result
// transaction with pressed, released, repeat and held masks. A sample is taken
// every cycle while the output is not stalled; it passes the input register, then
// the result register, and the countdown update of all buttons in parallel sets
// the rate of one sample per clock. Delays written as 0 are stored as 1; delays
// above the counter range saturate. The user must write configuration only while
// no sample is in flight; the block itself does not enforce this.
`include "button_edge_autorepeat_assert.svh"

module button_edge_autorepeat
  import bea_pkg::*;
#(
  parameter int NUM_BUTTONS   = 10,
  parameter int COUNTER_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [13:0] held_buttons
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [13:0] pressed_mask, [27:14] released_mask,
                                                 // [37:28] repeat_mask, [51:38] held_mask
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [15:0] COUNT_MAX = 16'((32'd1 << COUNTER_WIDTH) - 32'd1);

  function automatic logic [COUNTER_WIDTH-1:0] clamp_delay(input logic [CFG_DATA_W-1:0] v);
    logic [15:0] d;
    d = {8'd0, v};
    if (d == 16'd0) d = 16'd1;
    if (d > COUNT_MAX) d = COUNT_MAX;
    return d[COUNTER_WIDTH-1:0];
  endfunction

  logic [COUNTER_WIDTH-1:0] start_delay;
  logic [COUNTER_WIDTH-1:0] period_delay;
  logic                     in_valid;
  logic [HELD_W-1:0]        in_held;
  logic                     advance;
  res_t                     core_res;
  res_t                     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay  <= clamp_delay(START_DELAY_RST);
      period_delay <= clamp_delay(PERIOD_DELAY_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START_DELAY) begin
        start_delay <= clamp_delay(cfg_data);
      end else if (cfg_index == CFG_PERIOD_DELAY) begin
        period_delay <= clamp_delay(cfg_data);
      end
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_held <= s_axis_tdata[HELD_W-1:0];
    end
  end

  bea_core #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .held        (in_held),
    .start_delay (start_delay),
    .period_delay(period_delay),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - RES_W)'(0), out_res};

  `BEA_ASSERT_NOW(a_press_release_disjoint, m_axis_tvalid, (out_res.pressed_mask & out_res.released_mask) == '0, "pressed and released overlap")
  `BEA_ASSERT_NOW(a_repeat_only_held, m_axis_tvalid, (out_res.repeat_mask & ~out_res.held_mask[REPEAT_W-1:0]) == '0, "repeat pulse on a button not held")
  `BEA_ASSERT_NOW(a_press_only_held, m_axis_tvalid, (out_res.pressed_mask & ~out_res.held_mask) == '0, "press reported on a button not held")
  `BEA_ASSERT_NEXT(a_stage_moves, in_valid && !m_axis_tvalid, m_axis_tvalid, "staged sample did not reach result register")

endmodule
